>>> sv/wildcard_byte_signature_scan_unit_assert.svh
// Assertion macros used by the port-level signature scan checker.
`ifndef WILDCARD_BYTE_SIGNATURE_SCAN_UNIT_ASSERT_SVH
`define WILDCARD_BYTE_SIGNATURE_SCAN_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define WBSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define WBSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/wbss_pkg.sv
// Shared types and constants of the wildcard byte signature scanner.
package wbss_pkg;

   localparam int unsigned DATA_W      = 8;
   localparam int unsigned ADDR_W      = 64;
   localparam int unsigned LEN_W       = 6;
   localparam int unsigned MASK_W      = 32;
   localparam int unsigned PAT_WORD_W  = 64;
   localparam int unsigned PAT_WORDS   = 4;
   localparam int unsigned PAT_BYTES   = 32;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;

   localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;

   typedef logic [DATA_W-1:0] byte_type;
   typedef logic [ADDR_W-1:0] addr_type;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAT_LOW    = 3'd0,
      CSR_PAT_SECOND = 3'd1,
      CSR_PAT_THIRD  = 3'd2,
      CSR_PAT_HIGH   = 3'd3,
      CSR_WILDCARD   = 3'd4,
      CSR_LENGTH     = 3'd5
   } csr_index_type;

endpackage

>>> sv/wbss_if.sv
// Valid/ready channel interfaces for scanned bytes and match results.
interface wbss_req_if;
   logic                valid;
   logic                ready;
   wbss_pkg::byte_type  data_byte;
   wbss_pkg::addr_type  byte_address;
   logic                region_first;

   modport source (output valid, data_byte, byte_address, region_first, input ready);
   modport sink   (input valid, data_byte, byte_address, region_first, output ready);
endinterface

interface wbss_rsp_if;
   logic                valid;
   logic                ready;
   wbss_pkg::addr_type  match_address;

   modport source (output valid, match_address, input ready);
   modport sink   (input valid, match_address, output ready);
endinterface

>>> sv/wildcard_byte_signature_scan_unit.sv
// Wildcard byte signature scanner: top level.
// The scanner takes one byte item per cycle and, when the last pattern_length
// bytes of the current region match the configured signature (wildcard bytes
// match anything), returns the address of the first byte of the match. An item
// passes through an input register and one compare stage that checks every
// pattern position in parallel against a shift window of the previous bytes
// and loads the result register, so the sustained rate is one item per clock;
// the only stall comes from the result side. A region_first item clears the
// window, so matches never cross regions, and a region shorter than the pattern
// gives nothing. Lengths above PATTERN_MAX act as PATTERN_MAX and a length of
// zero never matches. The user must write configuration only while the scanner
// is idle; the block itself does not enforce this.
module wildcard_byte_signature_scan_unit #(
   parameter int unsigned PATTERN_MAX = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   wbss_req_if.sink                            req_if,
   wbss_rsp_if.source                          rsp_if,
   input  logic                                csr_write_enable,
   input  logic [wbss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wbss_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int unsigned WIN_DEPTH = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
   localparam int unsigned IDX_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int unsigned CNT_W     = $clog2(PATTERN_MAX + 1);
   localparam int unsigned LEN_W     = wbss_pkg::LEN_W;
   localparam int unsigned ADDR_W    = wbss_pkg::ADDR_W;
   localparam int unsigned DATA_W    = wbss_pkg::DATA_W;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PATTERN_MAX);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

   // Configuration registers
   logic [wbss_pkg::PAT_WORD_W-1:0]             pat_word_ff [wbss_pkg::PAT_WORDS];
   logic [wbss_pkg::MASK_W-1:0]                 wildcard_ff;
   logic [LEN_W-1:0]                            length_ff;
   logic [wbss_pkg::PAT_BYTES*DATA_W-1:0]       pat_flat;

   // Input stage
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   wbss_pkg::byte_type   s1_byte_ff;
   wbss_pkg::addr_type   s1_addr_ff;
   logic                 s1_first_ff;

   // Scan state
   wbss_pkg::byte_type   win_ff [WIN_DEPTH];
   wbss_pkg::byte_type   win_in [WIN_DEPTH];
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;

   // Result register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   wbss_pkg::addr_type   rsp_addr_ff;

   logic                 req_accept;
   logic                 advance;
   logic [LEN_W-1:0]     len_eff;
   wbss_pkg::byte_type   hist [PATTERN_MAX];
   logic                 all_ok;
   logic                 found;
   wbss_pkg::addr_type   match_addr;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < wbss_pkg::PAT_WORDS; w++) begin
            pat_word_ff[w] <= '0;
         end
         wildcard_ff <= '0;
         length_ff   <= wbss_pkg::LEN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            wbss_pkg::CSR_PAT_LOW:    pat_word_ff[0] <= csr_write_data;
            wbss_pkg::CSR_PAT_SECOND: pat_word_ff[1] <= csr_write_data;
            wbss_pkg::CSR_PAT_THIRD:  pat_word_ff[2] <= csr_write_data;
            wbss_pkg::CSR_PAT_HIGH:   pat_word_ff[3] <= csr_write_data;
            wbss_pkg::CSR_WILDCARD:   wildcard_ff    <= csr_write_data[wbss_pkg::MASK_W-1:0];
            wbss_pkg::CSR_LENGTH:     length_ff      <= csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign pat_flat = {pat_word_ff[3], pat_word_ff[2], pat_word_ff[1], pat_word_ff[0]};

   // Handshake: the pipeline moves whenever the result register is free
   assign advance       = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = !s1_valid_ff || advance;
   assign req_accept    = req_if.valid && req_if.ready;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.match_address = rsp_addr_ff;

   assign len_eff = (length_ff > LEN_MAX) ? LEN_MAX : length_ff;

   // Byte history, most recent first; a new region sees an empty window
   always_comb begin
      hist[0] = s1_byte_ff;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         hist[k] = s1_first_ff ? '0 : win_ff[k-1];
      end
   end

   // Saturating region count, current byte included
   always_comb begin
      if (s1_first_ff) begin
         count_in = CNT_W'(1);
      end else if (count_ff == CNT_MAX) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + 1'b1;
      end
   end

   // Compare all pattern positions at once; position j looks back len-1-j
   always_comb begin
      logic [LEN_W-1:0] back;
      all_ok = 1'b1;
      back   = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if (LEN_W'(j) < len_eff) begin
            back = len_eff - LEN_W'(j) - LEN_W'(1);
            if (!wildcard_ff[j] &&
                hist[back[IDX_W-1:0]] != pat_flat[j*DATA_W +: DATA_W]) begin
               all_ok = 1'b0;
            end
         end
      end
   end

   assign found = (len_eff != '0) && (LEN_W'(count_in) >= len_eff) && all_ok;
   assign match_addr = s1_addr_ff - ADDR_W'(len_eff - LEN_W'(1));

   // Window shift
   always_comb begin
      win_in[0] = s1_byte_ff;
      for (int k = 1; k < WIN_DEPTH; k++) begin
         win_in[k] = hist[k];
      end
   end

   assign s1_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? (s1_valid_ff && found) : rsp_valid_ff;

   // Control and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         for (int k = 0; k < WIN_DEPTH; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_valid_ff && advance) begin
            count_ff <= count_in;
            win_ff   <= win_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff  <= req_if.data_byte;
         s1_addr_ff  <= req_if.byte_address;
         s1_first_ff <= req_if.region_first;
      end
      if (s1_valid_ff && advance && found) begin
         rsp_addr_ff <= match_addr;
      end
   end

endmodule

>>> sv/wbss_checker.sv
// Port-level checks of the signature scanner and their bind.
`include "wildcard_byte_signature_scan_unit_assert.svh"

module wbss_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  wbss_pkg::addr_type  rsp_match_address
);

   logic req_accept;

   assign req_accept = req_valid && req_ready;

   // A stalled result keeps its address
   `WBSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_match_address), "stalled result changed")

   // Reset leaves no result pending
   `WBSS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // Input side never waits while the result register is free
   `WBSS_ASSERT_SAME(a_ready_free, clock, reset, !rsp_valid || rsp_ready, req_ready, "input stalled with free result register")

   // With no item in flight no result can appear
   `WBSS_ASSERT_NEXT(a_no_phantom, clock, reset, (!rsp_valid && !req_accept) ##1 (!rsp_valid && !req_accept), !rsp_valid, "result without an item")

endmodule

bind wildcard_byte_signature_scan_unit wbss_checker u_wbss_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_match_address (rsp_if.match_address)
);

>>> tb/sv/wildcard_byte_signature_scan_unit_checker.sv
// Checker for the signature scanner: predicts match addresses and compares returned ones.
module wildcard_byte_signature_scan_unit_checker
   import wbss_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   wbss_req_if                    req_mon,
   wbss_rsp_if                    rsp_mon,
   output int unsigned            error_count,
   output int unsigned            pending_matches,
   output int unsigned            bytes_scanned,
   output int unsigned            matches_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SHOWN_MISMATCHES = 10;

   // Shadow copy of the signature registers
   logic [PAT_WORD_W-1:0] sig_words [PAT_WORDS];
   logic [MASK_W-1:0]     sig_wild;
   logic [LEN_W-1:0]      sig_len;

   // Shadow of the byte history and region fill level
   byte_type              history [PAT_BYTES-1];
   logic [LEN_W-1:0]      region_fill;

   addr_type              expected_starts [$];
   int unsigned           errs;
   int unsigned           scanned;
   int unsigned           compared;

   assign error_count     = errs;
   assign bytes_scanned   = scanned;
   assign matches_checked = compared;

   initial begin
      errs     = 0;
      scanned  = 0;
      compared = 0;
   end

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] index,
                                     input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_PAT_LOW, CSR_PAT_SECOND, CSR_PAT_THIRD, CSR_PAT_HIGH: begin
            sig_words[index[1:0]] = data;
         end
         CSR_WILDCARD: begin
            sig_wild = data[MASK_W-1:0];
         end
         CSR_LENGTH: begin
            sig_len = data[LEN_W-1:0];
         end
         default: begin
            // unused index: write has no effect
         end
      endcase
   endfunction

   // One scanned byte: update history, return 1 and the start address on a full match
   function automatic bit predict_match(input byte_type cur, input addr_type addr,
                                        input logic first, output addr_type start);
      int unsigned span;
      int unsigned j;
      int unsigned back;
      bit          hit;
      byte_type    seen;
      span = (sig_len > PAT_BYTES) ? PAT_BYTES : sig_len;
      if (first) begin
         history     = '{default: '0};
         region_fill = '0;
      end
      if (region_fill < PAT_BYTES) region_fill++;
      hit = (span != 0) && (region_fill >= span);
      for (j = 0; j < span; j++) begin
         back = span - 1 - j;
         seen = (back == 0) ? cur : history[back - 1];
         if (!sig_wild[j] && seen != sig_words[j / 8][8 * (j % 8) +: 8]) hit = 1'b0;
      end
      start = addr - (addr_type'(span) - 1'b1);
      // newest byte goes to the front of the history
      for (j = PAT_BYTES - 2; j > 0; j--) history[j] = history[j - 1];
      history[0] = cur;
      return hit;
   endfunction

   function automatic void note_mismatch(input string what, input addr_type want,
                                         input addr_type got);
      errs++;
      if (errs <= SHOWN_MISMATCHES)
         $display("%0t ns: %s: expected match_address %h, got %h", $time, what, want, got);
   endfunction

   always @(posedge clock) begin
      addr_type start;
      addr_type want;
      if (reset) begin
         sig_words   = '{default: '0};
         sig_wild    = '0;
         sig_len     = LEN_RESET;
         history     = '{default: '0};
         region_fill = '0;
         expected_starts.delete();
      end else begin
         if (csr_write_enable) apply_csr(csr_index, csr_write_data);
         // returned match against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            compared++;
            if (expected_starts.size() == 0) begin
               note_mismatch("match with none predicted", '0, rsp_mon.match_address);
            end else begin
               want = expected_starts.pop_front();
               if (rsp_mon.match_address !== want)
                  note_mismatch("wrong match address", want, rsp_mon.match_address);
            end
         end
         // accepted byte item, prediction queued at the tail
         if (req_mon.valid && req_mon.ready) begin
            scanned++;
            if (predict_match(req_mon.data_byte, req_mon.byte_address, req_mon.region_first,
                              start))
               expected_starts.insert(expected_starts.size(), start);
         end
      end
      pending_matches <= expected_starts.size();
   end

endmodule

>>> tb/sv/wildcard_byte_signature_scan_unit_tb.sv
// Testbench top for the signature scanner: clock, reset, byte stimulus and verdict.
module wildcard_byte_signature_scan_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wbss_pkg::*;

   localparam int unsigned CLK_HIGH     = 4;
   localparam int unsigned CLK_LOW      = 4;
   localparam int unsigned RESET_CYCLES = 6;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned PHASES       = 14;
   localparam int unsigned PHASE_ITEMS  = 95;
   localparam int unsigned FIXED_LENS   = 9;
   localparam int unsigned FF_PHASE     = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam byte_type SIG_HEAD = 8'hA5;
   localparam byte_type SIG_TAIL = 8'h5A;

   // lengths of the leading phases: extremes, zero and out-of-range values
   localparam int unsigned FIXED_LEN [FIXED_LENS] = '{1, 32, 0, 33, 63, 2, 31, 8, 32};

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   wbss_req_if req_if ();
   wbss_rsp_if rsp_if ();

   int unsigned error_count;
   int unsigned pending_matches;
   int unsigned bytes_scanned;
   int unsigned matches_checked;
   int unsigned cycle_count = 0;

   // stimulus-side copy of what was written
   logic [PAT_WORD_W-1:0] cur_words [PAT_WORDS];
   logic [MASK_W-1:0]     cur_mask;
   logic [LEN_W-1:0]      cur_len;
   addr_type              next_addr;
   int unsigned           items_sent = 0;
   bit                    calm = 1'b0;

   wildcard_byte_signature_scan_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   wildcard_byte_signature_scan_unit_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .error_count      (error_count),
      .pending_matches  (pending_matches),
      .bytes_scanned    (bytes_scanned),
      .matches_checked  (matches_checked)
   );

   always begin
      #CLK_LOW clock = 1'b1;
      #CLK_HIGH clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d matches outstanding",
                  pending_matches);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Mostly no gap, some short, a few long; none at all in calm phases
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      else if (roll < 88) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // Result side back-pressure
   initial begin
      int unsigned hold;
      int unsigned stall;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= 1'b1;
         hold = $urandom_range(1, 24);
         repeat (hold) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // Write every register from the cur_* copy, upper bits sometimes junk
   task automatic load_settings();
      logic [CSR_DATA_W-1:0] junk;
      int unsigned w;
      junk = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
      for (w = 0; w < PAT_WORDS; w++) write_reg(CSR_INDEX_W'(CSR_PAT_LOW + w), cur_words[w]);
      write_reg(CSR_WILDCARD, {junk[CSR_DATA_W-1:MASK_W], cur_mask});
      write_reg(CSR_LENGTH, {junk[CSR_DATA_W-1:LEN_W], cur_len});
      // an unused index must not disturb anything
      write_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, {$urandom, $urandom});
      csr_write_enable <= 1'b0;
   endtask

   // Offer one byte item at next_addr and hold it until taken
   task automatic push_byte(input byte_type value, input logic first);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.data_byte    <= value;
      req_if.byte_address <= next_addr;
      req_if.region_first <= first;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      next_addr++;
      items_sent++;
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_matches != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_noise(input int unsigned count);
      int unsigned k;
      for (k = 0; k < count; k++) push_byte(byte_type'($urandom), $urandom_range(0, 7) == 0);
   endtask

   // One copy of the signature, random bytes on wildcards; optionally one
   // fixed byte damaged or a new region started partway through
   task automatic send_signature(input bit corrupt, input bit split);
      int unsigned span;
      int unsigned bad;
      int unsigned j;
      byte_type    value;
      span = (cur_len > PAT_BYTES) ? PAT_BYTES : cur_len;
      if (span == 0) return;
      bad = $urandom_range(0, span - 1);
      for (j = 0; j < span; j++) begin
         value = cur_mask[j] ? byte_type'($urandom) : cur_words[j / 8][8 * (j % 8) +: 8];
         if (corrupt && j == bad && !cur_mask[j])
            value ^= byte_type'(1 << $urandom_range(0, 7));
         push_byte(value, split && j == bad && j != 0);
      end
   endtask

   task automatic run_segment();
      int unsigned kind;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3: begin
            push_noise($urandom_range(0, 6));
            send_signature(1'b0, 1'b0);
         end
         4: begin
            push_noise($urandom_range(0, 6));
            send_signature(1'b1, 1'b0);
         end
         5: begin
            push_noise($urandom_range(0, 3));
            send_signature(1'b0, 1'b1);
         end
         6, 7: begin
            push_noise($urandom_range(1, 12));
         end
         8: begin
            // jump to a new region near either end of the address space or anywhere
            case ($urandom_range(0, 2))
               0: next_addr = addr_type'($urandom_range(0, 40));
               1: next_addr = '1 - addr_type'($urandom_range(0, 40));
               default: next_addr = {$urandom, $urandom};
            endcase
            push_byte(byte_type'($urandom), 1'b1);
            send_signature(1'b0, 1'b0);
         end
         default: begin
            // fresh region, then two copies back to back
            push_byte(byte_type'($urandom), 1'b1);
            send_signature(1'b0, 1'b0);
            send_signature(1'b0, 1'b0);
         end
      endcase
   endtask

   initial begin
      int unsigned phase;
      int unsigned w;
      int unsigned quota;
      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_index           <= '0;
      csr_write_data      <= '0;
      req_if.valid        <= 1'b0;
      req_if.data_byte    <= '0;
      req_if.byte_address <= '0;
      req_if.region_first <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: one-byte signature of zero
      calm      = 1'b1;
      next_addr = '0;
      push_byte(8'h00, 1'b1);
      next_addr = '1 - 1'b1;
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h80, 1'b0);
      wait_idle();

      // Three-byte signature, middle byte wildcard
      for (w = 0; w < PAT_WORDS; w++) cur_words[w] = {$urandom, $urandom};
      cur_words[0][7:0]   = SIG_HEAD;
      cur_words[0][23:16] = SIG_TAIL;
      cur_mask            = 32'h0000_0002;
      cur_len             = 6'd3;
      load_settings();
      calm = 1'b0;
      next_addr = 64'd1;
      push_byte(SIG_HEAD, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(SIG_TAIL, 1'b0);
      // region restarts before the signature completes
      push_byte(SIG_HEAD, 1'b1);
      push_byte(8'h3C, 1'b0);
      push_byte(SIG_TAIL, 1'b1);
      // match whose start lies just below address zero
      next_addr = '1;
      push_byte(SIG_HEAD, 1'b1);
      push_byte(8'h7E, 1'b0);
      push_byte(SIG_TAIL, 1'b0);
      // fixed byte off by one
      push_byte(SIG_HEAD, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(SIG_TAIL ^ 8'h01, 1'b0);
      // repeated head byte
      push_byte(SIG_HEAD, 1'b0);
      push_byte(SIG_HEAD, 1'b0);
      push_byte(SIG_TAIL, 1'b0);
      wait_idle();

      // Random phases, each under its own settings
      for (phase = 0; phase < PHASES; phase++) begin
         calm = (phase % 5 == 3);
         for (w = 0; w < PAT_WORDS; w++)
            cur_words[w] = (phase == FF_PHASE) ? '1 : {$urandom, $urandom};
         case (phase % 4)
            0: cur_mask = '0;
            1: cur_mask = '1;
            2: cur_mask = $urandom & $urandom & $urandom;
            default: cur_mask = $urandom;
         endcase
         cur_len = (phase < FIXED_LENS) ? LEN_W'(FIXED_LEN[phase])
                                        : LEN_W'($urandom_range(1, PAT_BYTES));
         load_settings();
         next_addr = {$urandom, $urandom};
         quota     = items_sent + PHASE_ITEMS;
         while (items_sent < quota) run_segment();
         wait_idle();
      end

      $display("Scanned %0d byte items under %0d signature settings;", bytes_scanned,
               PHASES + 2);
      $display("%0d match addresses came back and were compared.", matches_checked);
      if (error_count == 0 && pending_matches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/wbss_pkg.sv
sv/wbss_if.sv
sv/wildcard_byte_signature_scan_unit.sv
sv/wbss_checker.sv
tb/sv/wildcard_byte_signature_scan_unit_checker.sv
tb/sv/wildcard_byte_signature_scan_unit_tb.sv
